[design/fhd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the frame header deframer.
// No dependencies.
package fhd_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TDATA_W   = 48;

	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_THIRD  = 2'd2;

	// header positions after the magic bytes
	localparam logic [2:0] HDR_LEN_LAST = 3'd3;
	localparam logic [2:0] HDR_CHECK    = 3'd4;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] third;
	} magic_t;

	typedef struct packed {
		logic [7:0]  msg_type;
		logic [7:0]  data_byte;
		logic        has_data;
		logic        last;
		logic [31:0] msg_length;
	} res_t;

endpackage

[design/frame_header_deframer_top.sv]
`timescale 1ns / 1ps
// A result word reaches m_axis from the output register; one pushed while it is stalled waits in the skid stage.
// Throughput: one byte per cycle; s_axis_tready falls only when both output
// stages hold words (output register plus skid stage).
// Reset: arst_n clears the parser to hunting, empties the output stages and
// sets all three magic registers to zero. Config writes are always accepted.
module frame_header_deframer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // rx_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// data_byte[7:0], has_data[8], msg_length[40:9], zero[47:41]
	output logic [fhd_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic [7:0]                        m_axis_tuser,  // msg_type
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fhd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                        cfg_data
);

	fhd_pkg::magic_t magic_q;
	fhd_pkg::res_t   res;
	fhd_pkg::res_t   out_res;
	logic            res_valid;
	logic            byte_acc;
	logic            in_ready;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = in_ready;
	assign byte_acc      = s_axis_tvalid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				fhd_pkg::CFG_MAGIC_FIRST:  magic_q.first  <= cfg_data;
				fhd_pkg::CFG_MAGIC_SECOND: magic_q.second <= cfg_data;
				fhd_pkg::CFG_MAGIC_THIRD:  magic_q.third  <= cfg_data;
				default: ;
			endcase
		end
	end

	fhd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_acc),
		.rx_byte   (s_axis_tdata),
		.magic     (magic_q),
		.res_valid (res_valid),
		.res       (res)
	);

	fhd_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.in_ready (in_ready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {7'd0, out_res.msg_length, out_res.has_data, out_res.data_byte};
	assign m_axis_tuser = out_res.msg_type;
	assign m_axis_tlast = out_res.last;

endmodule

[design/fhd_parser.sv]
`timescale 1ns / 1ps
// Frame parser: hunt, magic check, header capture and payload count.
// One byte per cycle; uses fhd_pkg types.
module fhd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	input  logic [7:0]    rx_byte,
	input  fhd_pkg::magic_t magic,
	output logic          res_valid,
	output fhd_pkg::res_t res
);

	typedef enum logic [1:0] {
		HUNT,
		MAGIC,
		HEADER,
		PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hidx_q, hidx_d;
	logic        magic_ok_q, magic_ok_d;
	logic [31:0] length_q, length_d;
	logic [2:0]  sum_q, sum_d;
	logic [7:0]  check_q, check_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] remaining_q, remaining_d;
	logic [2:0]  sum_inc;

	assign sum_inc = sum_q + {2'b00, rx_byte[0]};

	always_comb begin
		phase_d     = phase_q;
		hidx_d      = hidx_q;
		magic_ok_d  = magic_ok_q;
		length_d    = length_q;
		sum_d       = sum_q;
		check_d     = check_q;
		type_d      = type_q;
		remaining_d = remaining_q;
		res_valid   = 1'b0;
		res.msg_type   = type_q;
		res.data_byte  = 8'd0;
		res.has_data   = 1'b0;
		res.last       = 1'b1;
		res.msg_length = length_q;
		if (byte_valid) begin
			unique case (phase_q)
				HUNT: begin
					if (rx_byte == magic.first) begin
						phase_d    = MAGIC;
						hidx_d     = 3'd0;
						magic_ok_d = 1'b1;
						sum_d      = {2'b00, rx_byte[0]};
					end
				end
				MAGIC: begin
					sum_d = sum_inc;
					if (hidx_q == 3'd0) begin
						if (rx_byte != magic.second) magic_ok_d = 1'b0;
						hidx_d = 3'd1;
					end else begin
						hidx_d = 3'd0;
						if (magic_ok_q && rx_byte == magic.third) begin
							phase_d  = HEADER;
							length_d = 32'd0;
						end else begin
							phase_d = HUNT;
						end
					end
				end
				HEADER: begin
					if (hidx_q <= fhd_pkg::HDR_LEN_LAST) begin
						length_d = {length_q[23:0], rx_byte};
						sum_d    = sum_inc;
						hidx_d   = hidx_q + 3'd1;
					end else if (hidx_q == fhd_pkg::HDR_CHECK) begin
						check_d = rx_byte;
						hidx_d  = hidx_q + 3'd1;
					end else begin
						type_d = rx_byte;
						hidx_d = 3'd0;
						if (check_q != {5'd0, sum_q}) begin
							phase_d = HUNT;
						end else if (length_q == 32'd0) begin
							// empty frame notice
							phase_d      = HUNT;
							res_valid    = 1'b1;
							res.msg_type = rx_byte;
						end else begin
							remaining_d = length_q;
							phase_d     = PAYLOAD;
						end
					end
				end
				PAYLOAD: begin
					remaining_d   = remaining_q - 32'd1;
					res_valid     = 1'b1;
					res.data_byte = rx_byte;
					res.has_data  = 1'b1;
					res.last      = (remaining_q == 32'd1);
					if (remaining_q == 32'd1) phase_d = HUNT;
				end
				default: phase_d = HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= HUNT;
			hidx_q      <= 3'd0;
			magic_ok_q  <= 1'b0;
			length_q    <= 32'd0;
			sum_q       <= 3'd0;
			check_q     <= 8'd0;
			type_q      <= 8'd0;
			remaining_q <= 32'd0;
		end else begin
			phase_q     <= phase_d;
			hidx_q      <= hidx_d;
			magic_ok_q  <= magic_ok_d;
			length_q    <= length_d;
			sum_q       <= sum_d;
			check_q     <= check_d;
			type_q      <= type_d;
			remaining_q <= remaining_d;
		end
	end

`ifndef SYNTHESIS
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PAYLOAD |-> remaining_q != 32'd0)
		else $error("payload phase with zero bytes remaining");
	a_hunt_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == HUNT |-> hidx_q == 3'd0)
		else $error("hunting with nonzero header index");
	a_magic_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == MAGIC |-> (hidx_q == 3'd0 || hidx_q == 3'd1))
		else $error("magic phase index out of range");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_valid && (phase_q == PAYLOAD || phase_q == HEADER))
		else $error("result without a payload or header word");
`endif

endmodule

[design/fhd_outbuf.sv]
`timescale 1ns / 1ps
// Output register with skid stage for result words.
// Uses fhd_pkg::res_t.
module fhd_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fhd_pkg::res_t push_res,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output fhd_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	fhd_pkg::res_t out_q;
	fhd_pkg::res_t skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) out_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (push) out_q <= push_res;
		end else if (push) begin
			if (!out_valid_q) out_q <= push_res;
			else skid_q <= push_res;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held with empty output register");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("word pushed while both stages full");
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> !skid_valid_q && out_valid_q)
		else $error("skid word not moved on drain");
`endif

endmodule
